/* rtl/core/gcid_pkg.sv */
// Shared types, constants and register codes of the grid cell index block.
package gcid_pkg;

  // Field widths
  localparam int unsigned MAX_LEVELS = 8;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned INT_W      = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned PT_W       = INT_W + FRAC_W;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned DIST_W     = PT_W + 1;
  localparam int unsigned RAD_W      = 2 * DIST_W;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned REM_W      = PT_W + QUO_W;
  localparam int unsigned SQ_REM_W   = DIST_W + 2;
  localparam int unsigned SQ_STEPS   = 2;
  localparam int unsigned SQ_STAGES  = (DIST_W + SQ_STEPS - 1) / SQ_STEPS;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_LEVELS  = 2'd0,
    CFG_AREA_WIDTH  = 2'd1,
    CFG_AREA_HEIGHT = 2'd2
  } gcid_cfg_e;

  typedef struct packed {
    logic [LVL_W-1:0]  num_levels;
    logic [INT_W-1:0]  area_width;
    logic [INT_W-1:0]  area_height;
  } gcid_cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0]         level;
    logic signed [PT_W-1:0]   point_x;
    logic signed [PT_W-1:0]   point_y;
    logic [CELL_W-1:0]        cluster_id;
  } gcid_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] point_cell;
    logic              cell_error;
    logic [INT_W-1:0]  centre_x;
    logic [INT_W-1:0]  centre_y;
    logic              centre_error;
    logic [DIST_W-1:0] distance;
    logic              distance_error;
  } gcid_out_t;

  // Answers that ride along with the square root pipeline
  typedef struct packed {
    logic [CELL_W-1:0] point_cell;
    logic              cell_error;
    logic [INT_W-1:0]  centre_x;
    logic [INT_W-1:0]  centre_y;
    logic              centre_error;
    logic              distance_error;
  } gcid_tag_t;

  typedef struct packed {
    logic [RAD_W-1:0] radicand;
    gcid_tag_t        tag;
  } gcid_mid_t;

endpackage

/* rtl/core/gcid_front.sv */
// Front pipeline: level decode, cell division, cluster centre and squared distance.
module gcid_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  gcid_pkg::gcid_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  input  gcid_pkg::gcid_in_t   in_req_i,
  output logic                 out_valid_o,
  output gcid_pkg::gcid_mid_t  out_mid_o
);

  localparam int unsigned NST = 4;

  typedef struct packed {
    logic [gcid_pkg::LVL_W-1:0]  sh;
    logic                        cell_err;
    logic                        cen_err;
    logic                        dist_err;
    logic                        pos_x;
    logic                        pos_y;
    logic [gcid_pkg::REM_W-1:0]  rem_x;
    logic [gcid_pkg::REM_W-1:0]  rem_y;
    logic [gcid_pkg::PT_W-1:0]   div_x;
    logic [gcid_pkg::PT_W-1:0]   div_y;
    logic [gcid_pkg::QUO_W-1:0]  q_x;
    logic [gcid_pkg::QUO_W-1:0]  q_y;
    logic [gcid_pkg::PT_W-1:0]   px;
    logic [gcid_pkg::PT_W-1:0]   py;
    logic [gcid_pkg::DIST_W-1:0] prod_x;
    logic [gcid_pkg::DIST_W-1:0] prod_y;
    logic [gcid_pkg::INT_W-1:0]  cx;
    logic [gcid_pkg::INT_W-1:0]  cy;
    logic [gcid_pkg::DIST_W-1:0] ax;
    logic [gcid_pkg::DIST_W-1:0] ay;
    logic [gcid_pkg::RAD_W-1:0]  sq_x;
    logic [gcid_pkg::RAD_W-1:0]  sq_y;
  } fr_t;

  fr_t                  st_q [NST];
  fr_t                  st_d [NST];
  logic [NST:0]         vld_q;
  gcid_pkg::gcid_mid_t  mid_q;
  gcid_pkg::gcid_mid_t  mid_d;

  // Two restoring division steps on both axes, top quotient bit first
  function automatic fr_t div_two(fr_t s, logic [2:0] hi);
    fr_t                        r;
    logic [2:0]                 b;
    logic [gcid_pkg::REM_W-1:0] tx;
    logic [gcid_pkg::REM_W-1:0] ty;
    r = s;
    for (int k = 0; k < 2; k++) begin
      b  = hi - 3'(k);
      tx = {{gcid_pkg::QUO_W{1'b0}}, r.div_x} << b;
      ty = {{gcid_pkg::QUO_W{1'b0}}, r.div_y} << b;
      if (r.rem_x >= tx) begin
        r.rem_x  = r.rem_x - tx;
        r.q_x[b] = 1'b1;
      end
      if (r.rem_y >= ty) begin
        r.rem_y  = r.rem_y - ty;
        r.q_y[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Stage A: decode level, check ranges, form dividends and centre products
  always_comb begin
    logic                             lvl_ok;
    logic [gcid_pkg::LVL_W-1:0]       sh;
    logic [gcid_pkg::QUO_W:0]         dv;
    logic [gcid_pkg::QUO_W-1:0]       col;
    logic [gcid_pkg::QUO_W-1:0]       row;
    logic [gcid_pkg::CELL_W-1:0]      hi_id;
    logic                             beyond;
    logic                             neg;
    lvl_ok = (in_req_i.level != '0) && (in_req_i.level <= cfg_i.num_levels) &&
             (in_req_i.level <= gcid_pkg::LVL_W'(gcid_pkg::MAX_LEVELS));
    sh     = lvl_ok ? in_req_i.level : '0;
    dv     = (gcid_pkg::QUO_W+1)'(1) << sh;
    col    = in_req_i.cluster_id[gcid_pkg::QUO_W-1:0] & gcid_pkg::QUO_W'(dv - 1'b1);
    hi_id  = in_req_i.cluster_id >> sh;
    row    = hi_id[gcid_pkg::QUO_W-1:0];
    beyond = (in_req_i.point_x > $signed({1'b0, cfg_i.area_width, {gcid_pkg::FRAC_W{1'b0}}})) ||
             (in_req_i.point_y > $signed({1'b0, cfg_i.area_height, {gcid_pkg::FRAC_W{1'b0}}}));
    neg    = in_req_i.point_x[gcid_pkg::PT_W-1] || in_req_i.point_y[gcid_pkg::PT_W-1];
    st_d[0]          = '0;
    st_d[0].sh       = sh;
    st_d[0].cell_err = !lvl_ok || beyond;
    st_d[0].cen_err  = !lvl_ok || ((in_req_i.cluster_id >> {sh, 1'b0}) != '0);
    st_d[0].dist_err = st_d[0].cen_err || beyond || neg;
    st_d[0].pos_x    = !in_req_i.point_x[gcid_pkg::PT_W-1] && (in_req_i.point_x != '0);
    st_d[0].pos_y    = !in_req_i.point_y[gcid_pkg::PT_W-1] && (in_req_i.point_y != '0);
    st_d[0].rem_x    = ({{gcid_pkg::QUO_W{1'b0}}, in_req_i.point_x} << sh) - 1'b1;
    st_d[0].rem_y    = ({{gcid_pkg::QUO_W{1'b0}}, in_req_i.point_y} << sh) - 1'b1;
    st_d[0].div_x    = {cfg_i.area_width, {gcid_pkg::FRAC_W{1'b0}}};
    st_d[0].div_y    = {cfg_i.area_height, {gcid_pkg::FRAC_W{1'b0}}};
    st_d[0].px       = in_req_i.point_x;
    st_d[0].py       = in_req_i.point_y;
    st_d[0].prod_x   = gcid_pkg::DIST_W'(cfg_i.area_width) * gcid_pkg::DIST_W'({col, 1'b1});
    st_d[0].prod_y   = gcid_pkg::DIST_W'(cfg_i.area_height) * gcid_pkg::DIST_W'({row, 1'b1});
  end

  // Stage B: round the centre with a shift, division bits 7 and 6
  always_comb begin
    logic [gcid_pkg::DIST_W:0] sx;
    logic [gcid_pkg::DIST_W:0] sy;
    logic [gcid_pkg::DIST_W:0] dv;
    logic [gcid_pkg::LVL_W:0]  s1;
    st_d[1] = div_two(st_q[0], 3'd7);
    dv = (gcid_pkg::DIST_W+1)'(1) << st_q[0].sh;
    s1 = {1'b0, st_q[0].sh} + 1'b1;
    sx = ({1'b0, st_q[0].prod_x} + dv) >> s1;
    sy = ({1'b0, st_q[0].prod_y} + dv) >> s1;
    st_d[1].cx = st_q[0].cen_err ? '0 : sx[gcid_pkg::INT_W-1:0];
    st_d[1].cy = st_q[0].cen_err ? '0 : sy[gcid_pkg::INT_W-1:0];
  end

  // Stage C: absolute offsets from the centre, division bits 5 and 4
  always_comb begin
    logic [gcid_pkg::DIST_W-1:0] pxe;
    logic [gcid_pkg::DIST_W-1:0] pye;
    logic [gcid_pkg::DIST_W-1:0] cxe;
    logic [gcid_pkg::DIST_W-1:0] cye;
    st_d[2] = div_two(st_q[1], 3'd5);
    pxe = {1'b0, st_q[1].px};
    pye = {1'b0, st_q[1].py};
    cxe = {1'b0, st_q[1].cx, {gcid_pkg::FRAC_W{1'b0}}};
    cye = {1'b0, st_q[1].cy, {gcid_pkg::FRAC_W{1'b0}}};
    st_d[2].ax = (pxe >= cxe) ? (pxe - cxe) : (cxe - pxe);
    st_d[2].ay = (pye >= cye) ? (pye - cye) : (cye - pye);
  end

  // Stage D: square the offsets, division bits 3 and 2
  always_comb begin
    st_d[3] = div_two(st_q[2], 3'd3);
    st_d[3].sq_x = st_q[2].ax * st_q[2].ax;
    st_d[3].sq_y = st_q[2].ay * st_q[2].ay;
  end

  // Stage E: last division bits, cell id, sum of squares
  always_comb begin
    fr_t                         f;
    logic [gcid_pkg::CELL_W-1:0] qx;
    logic [gcid_pkg::CELL_W-1:0] qy;
    f  = div_two(st_q[3], 3'd1);
    qx = f.pos_x ? gcid_pkg::CELL_W'(f.q_x) : '0;
    qy = f.pos_y ? gcid_pkg::CELL_W'(f.q_y) : '0;
    mid_d.tag.point_cell     = f.cell_err ? '0 : (qx + (qy << f.sh));
    mid_d.tag.cell_error     = f.cell_err;
    mid_d.tag.centre_x       = f.cx;
    mid_d.tag.centre_y       = f.cy;
    mid_d.tag.centre_error   = f.cen_err;
    mid_d.tag.distance_error = f.dist_err;
    mid_d.radicand           = f.dist_err ? '0 : (f.sq_x + f.sq_y);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-1:0], in_valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        st_q[s] <= st_d[s];
      end
      mid_q <= mid_d;
    end
  end

  assign out_valid_o = vld_q[NST];
  assign out_mid_o   = mid_q;

endmodule

/* rtl/core/gcid_isqrt.sv */
// Pipelined digit-by-digit integer square root that carries the other answers along.
module gcid_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  gcid_pkg::gcid_mid_t         in_mid_i,
  output logic                        out_valid_o,
  output logic [gcid_pkg::DIST_W-1:0] out_root_o,
  output gcid_pkg::gcid_tag_t         out_tag_o
);

  localparam int unsigned NS = gcid_pkg::SQ_STAGES;

  typedef struct packed {
    logic [gcid_pkg::RAD_W-1:0]    rad;
    logic [gcid_pkg::SQ_REM_W-1:0] rem;
    logic [gcid_pkg::DIST_W-1:0]   root;
    gcid_pkg::gcid_tag_t           tag;
  } sq_t;

  sq_t          sq_q [NS];
  sq_t          sq_in [NS];
  sq_t          sq_d [NS];
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_in;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign sq_in[s].rad  = in_mid_i.radicand;
      assign sq_in[s].rem  = '0;
      assign sq_in[s].root = '0;
      assign sq_in[s].tag  = in_mid_i.tag;
      assign vld_in[s]     = in_valid_i;
    end else begin : g_next
      assign sq_in[s] = sq_q[s-1];
      assign vld_in[s] = vld_q[s-1];
    end

    // Take two root bits per stage, one in the last stage where the root width runs out
    always_comb begin
      logic [gcid_pkg::SQ_REM_W-1:0] r;
      logic [gcid_pkg::SQ_REM_W-1:0] t;
      sq_d[s] = sq_in[s];
      for (int k = 0; k < gcid_pkg::SQ_STEPS; k++) begin
        if (s * gcid_pkg::SQ_STEPS + k < gcid_pkg::DIST_W) begin
          r = {sq_d[s].rem[gcid_pkg::SQ_REM_W-3:0],
               sq_d[s].rad[gcid_pkg::RAD_W-1 -: 2]};
          t = {sq_d[s].root, 2'b01};
          sq_d[s].rad = sq_d[s].rad << 2;
          if (r >= t) begin
            sq_d[s].rem  = r - t;
            sq_d[s].root = {sq_d[s].root[gcid_pkg::DIST_W-2:0], 1'b1};
          end else begin
            sq_d[s].rem  = r;
            sq_d[s].root = {sq_d[s].root[gcid_pkg::DIST_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        sq_q[s] <= sq_d[s];
      end
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_root_o  = sq_q[NS-1].root;
  assign out_tag_o   = sq_q[NS-1].tag;

endmodule

/* rtl/core/grid_cell_index_and_distance.sv */
// Top level: configuration registers, input skid stage and pipeline control.
// Each request names a grid level, a 16.8 point and a cluster id; the block
// answers with the point's cell id, the cluster centre and the truncated
// Euclidean distance from point to centre, each with its own error flag.
// One request is taken per clock cycle while the output is not stalled, and each
// gives exactly one result. The pipeline has 5 stages of decode, cell
// division, centre rounding and squaring, then 13 stages of the square
// root, which resolves up to two root bits per stage. A skid register at the
// input holds one request while the output is stalled. Write the
// configuration registers only while no request is in flight.
module grid_cell_index_and_distance (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gcid_pkg::gcid_in_t              in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gcid_pkg::gcid_out_t             out_rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gcid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gcid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gcid_pkg::gcid_cfg_t          cfg_q;
  gcid_pkg::gcid_cfg_t          cfg_d;
  gcid_pkg::gcid_in_t           skid_q;
  logic                         skid_vld_q;
  logic                         skid_vld_d;
  logic                         en;
  logic                         pipe_vld;
  gcid_pkg::gcid_in_t           pipe_req;
  logic                         mid_vld;
  gcid_pkg::gcid_mid_t          mid;
  logic [gcid_pkg::DIST_W-1:0]  root;
  gcid_pkg::gcid_tag_t          tag;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (gcid_pkg::gcid_cfg_e'(cfg_index_i))
        gcid_pkg::CFG_NUM_LEVELS:  cfg_d.num_levels  = cfg_data_i[gcid_pkg::LVL_W-1:0];
        gcid_pkg::CFG_AREA_WIDTH:  cfg_d.area_width  = cfg_data_i;
        gcid_pkg::CFG_AREA_HEIGHT: cfg_d.area_height = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_levels  <= gcid_pkg::LVL_W'(gcid_pkg::MAX_LEVELS);
      cfg_q.area_width  <= '1;
      cfg_q.area_height <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Advance the whole pipeline unless a result waits on a stalled output
  assign en = !out_valid_o || !out_stall_i;

  // Skid stage: hold one request while the pipeline stands
  assign in_stall_o = skid_vld_q;
  assign pipe_vld   = skid_vld_q || in_valid_i;
  assign pipe_req   = skid_vld_q ? skid_q : in_req_i;

  always_comb begin
    skid_vld_d = skid_vld_q;
    if (en) begin
      skid_vld_d = 1'b0;
    end else if (in_valid_i && !skid_vld_q) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_vld_q) begin
      skid_q <= in_req_i;
    end
  end

  gcid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .in_valid_i  (pipe_vld),
    .in_req_i    (pipe_req),
    .out_valid_o (mid_vld),
    .out_mid_o   (mid)
  );

  gcid_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (mid_vld),
    .in_mid_i    (mid),
    .out_valid_o (out_valid_o),
    .out_root_o  (root),
    .out_tag_o   (tag)
  );

  // Assemble the result
  always_comb begin
    out_rsp_o.point_cell     = tag.point_cell;
    out_rsp_o.cell_error     = tag.cell_error;
    out_rsp_o.centre_x       = tag.centre_x;
    out_rsp_o.centre_y       = tag.centre_y;
    out_rsp_o.centre_error   = tag.centre_error;
    out_rsp_o.distance       = root;
    out_rsp_o.distance_error = tag.distance_error;
  end

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !en |=> skid_vld_q && $stable(skid_q))
    else $error("skid request lost while pipeline stalled");

  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.cell_error |-> out_rsp_o.point_cell == '0)
    else $error("cell id not cleared on cell error");

  a_centre_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.centre_error |->
      out_rsp_o.centre_x == '0 && out_rsp_o.centre_y == '0)
    else $error("centre not cleared on centre error");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.distance_error |-> out_rsp_o.distance == '0)
    else $error("distance not cleared on distance error");

  a_err_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.centre_error |-> out_rsp_o.distance_error)
    else $error("centre error without distance error");

endmodule
